>>> design/lte_pkg.sv
// Shared types and constants for the table energy correction block.
// No dependencies; used by every module of the block but lte_ram.
`timescale 1ns / 1ps
package lte_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned PolyOrderDef  = 4;

  // Fixed-point layout of basis factors and products
  localparam int unsigned FracBits = 24;
  localparam int unsigned NumW     = 57;  // |q - x| * 2^24
  localparam int unsigned DenW     = 33;  // |x_a - x_b|
  localparam int unsigned DivCntW  = 6;

  // Item commands
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdConvert = 1'b1;

  // Table columns
  localparam logic [1:0] ColEnergy   = 2'd0;
  localparam logic [1:0] ColMeasured = 2'd1;
  localparam logic [1:0] ColModel    = 2'd2;

  // Configuration register indexes
  localparam logic RegPoints  = 1'b0;
  localparam logic RegConvert = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    StIdle,
    StRdFirst,
    StChkFirst,
    StChkLast,
    StSearch,
    StARd,
    StALd,
    StB,
    StBChk,
    StDiv,
    StMul,
    StLam,
    StTerm,
    StAcc,
    StPend,
    StDone
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OpNone,
    OpLoad,
    OpRdFirst,
    OpTakeY,
    OpRdLast,
    OpSrchGo,
    OpSrchNext,
    OpWin,
    OpARd,
    OpALd,
    OpBInc,
    OpBRd,
    OpDead,
    OpDivGo,
    OpMulF,
    OpLam,
    OpMulY,
    OpAcc,
    OpPass2,
    OpOut
  } op_e;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic in_write;
    logic conv_en;
    logic q_le_x;
    logic q_ge_x;
    logic srch_more;
    logic b_done;
    logic b_is_a;
    logic den_zero;
    logic div_busy;
    logic a_last;
    logic pass_two;
    logic out_free;
  } status_t;

endpackage

>>> design/lte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lte_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lte_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on lte_pkg for operand widths.
`timescale 1ns / 1ps
module lte_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lte_pkg::NumW-1:0]  num_i,
  input  logic [lte_pkg::DenW-1:0]  den_i,
  output logic                      busy_o,
  output logic [lte_pkg::NumW-1:0]  quo_o
);

  logic [lte_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [lte_pkg::DenW:0]      rem_q, rem_d, rem_sh;
  logic [lte_pkg::NumW-1:0]    quo_q, quo_d;
  logic [lte_pkg::DenW-1:0]    den_q, den_d;
  logic                        qbit;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem_q[lte_pkg::DenW-1:0], quo_q[lte_pkg::NumW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = lte_pkg::DivCntW'(lte_pkg::NumW);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[lte_pkg::NumW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

>>> design/lte_ctrl.sv
// Controller state machine: sequences table reads, divisions and sums.
// Depends on lte_pkg for states, operations and status flags.
`timescale 1ns / 1ps
module lte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lte_pkg::status_t status_i,
  output lte_pkg::op_e     op_o
);

  lte_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lte_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (status_i.in_write || !status_i.conv_en) ? lte_pkg::StDone
                                                             : lte_pkg::StRdFirst;
        end
      end
      lte_pkg::StRdFirst:  state_d = lte_pkg::StChkFirst;
      lte_pkg::StChkFirst: state_d = status_i.q_le_x ? lte_pkg::StPend : lte_pkg::StChkLast;
      lte_pkg::StChkLast:  state_d = status_i.q_ge_x ? lte_pkg::StPend : lte_pkg::StSearch;
      lte_pkg::StSearch: begin
        if (!status_i.srch_more) state_d = lte_pkg::StARd;
      end
      lte_pkg::StARd: state_d = lte_pkg::StALd;
      lte_pkg::StALd: state_d = lte_pkg::StB;
      lte_pkg::StB: begin
        if (status_i.b_done) begin
          state_d = lte_pkg::StTerm;
        end else if (!status_i.b_is_a) begin
          state_d = lte_pkg::StBChk;
        end
      end
      lte_pkg::StBChk: state_d = status_i.den_zero ? lte_pkg::StTerm : lte_pkg::StDiv;
      lte_pkg::StDiv: begin
        if (!status_i.div_busy) state_d = lte_pkg::StMul;
      end
      lte_pkg::StMul:  state_d = lte_pkg::StLam;
      lte_pkg::StLam:  state_d = lte_pkg::StB;
      lte_pkg::StTerm: state_d = lte_pkg::StAcc;
      lte_pkg::StAcc:  state_d = status_i.a_last ? lte_pkg::StPend : lte_pkg::StARd;
      lte_pkg::StPend: state_d = status_i.pass_two ? lte_pkg::StDone : lte_pkg::StRdFirst;
      lte_pkg::StDone: begin
        if (status_i.out_free) state_d = lte_pkg::StIdle;
      end
      default: state_d = lte_pkg::StIdle;
    endcase
  end

  // datapath operation per state
  always_comb begin
    op_o = lte_pkg::OpNone;
    case (state_q)
      lte_pkg::StIdle:     if (in_valid_i) op_o = lte_pkg::OpLoad;
      lte_pkg::StRdFirst:  op_o = lte_pkg::OpRdFirst;
      lte_pkg::StChkFirst: op_o = status_i.q_le_x ? lte_pkg::OpTakeY : lte_pkg::OpRdLast;
      lte_pkg::StChkLast:  op_o = status_i.q_ge_x ? lte_pkg::OpTakeY : lte_pkg::OpSrchGo;
      lte_pkg::StSearch:   op_o = status_i.srch_more ? lte_pkg::OpSrchNext : lte_pkg::OpWin;
      lte_pkg::StARd:      op_o = lte_pkg::OpARd;
      lte_pkg::StALd:      op_o = lte_pkg::OpALd;
      lte_pkg::StB: begin
        if (status_i.b_done) begin
          op_o = lte_pkg::OpNone;
        end else if (status_i.b_is_a) begin
          op_o = lte_pkg::OpBInc;
        end else begin
          op_o = lte_pkg::OpBRd;
        end
      end
      lte_pkg::StBChk: op_o = status_i.den_zero ? lte_pkg::OpDead : lte_pkg::OpDivGo;
      lte_pkg::StMul:  op_o = lte_pkg::OpMulF;
      lte_pkg::StLam:  op_o = lte_pkg::OpLam;
      lte_pkg::StTerm: op_o = lte_pkg::OpMulY;
      lte_pkg::StAcc:  op_o = lte_pkg::OpAcc;
      lte_pkg::StPend: op_o = status_i.pass_two ? lte_pkg::OpNone : lte_pkg::OpPass2;
      lte_pkg::StDone: if (status_i.out_free) op_o = lte_pkg::OpOut;
      default:         op_o = lte_pkg::OpNone;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lte_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != lte_pkg::StIdle);

endmodule

>>> design/lte_dp.sv
// Datapath: table columns, configuration, search index, basis products and sum.
// Depends on lte_pkg, lte_ram and lte_div.
`timescale 1ns / 1ps
module lte_dp #(
  parameter int unsigned TableDepth = lte_pkg::TableDepthDef,
  parameter int unsigned PolyOrder  = lte_pkg::PolyOrderDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lte_pkg::op_e       op_i,
  output lte_pkg::status_t   status_o,
  input  logic               command_i,
  input  logic [1:0]         column_i,
  input  logic [4:0]         row_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] converted_energy_o,
  output logic signed [31:0] interpolated_range_o
);

  localparam int unsigned AW = $clog2(TableDepth > 1 ? TableDepth : 2);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned OW = $clog2(PolyOrder + 1);

  // configuration
  logic [5:0] points_q;
  logic       conv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= 6'd32;
      conv_q   <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lte_pkg::RegPoints) points_q <= cfg_data_i;
      if (cfg_index_i == lte_pkg::RegConvert) conv_q <= cfg_data_i[0];
    end
  end

  // point count clamped to the table, window order
  logic [CW-1:0] n_w, nm1_w, order_w;
  always_comb begin
    if (points_q == '0) begin
      n_w = CW'(1);
    end else if (32'(points_q) > 32'(TableDepth)) begin
      n_w = CW'(TableDepth);
    end else begin
      n_w = CW'(points_q);
    end
    nm1_w   = n_w - 1'b1;
    order_w = (32'(n_w) > 32'(PolyOrder)) ? CW'(PolyOrder) : n_w;
  end

  // item and pass registers
  logic               item_wr_q, item_conv_q, pass_q;
  logic signed [31:0] q_q, res_q, range_q, xa_q, ya_q;
  logic signed [32:0] lam_q;
  logic signed [47:0] sum_q;
  logic signed [65:0] prod_q;
  logic               dead_q, neg_q;
  logic [CW-1:0]      j_q;
  logic [OW-1:0]      a_q, b_q;

  // table columns, all read at one address
  logic [AW-1:0] raddr;
  logic [31:0]   e_rd, m_rd, d_rd;
  logic          wr_go, row_ok;
  logic [AW-1:0] waddr;

  assign row_ok = (32'(row_i) < 32'(TableDepth));
  assign wr_go  = (op_i == lte_pkg::OpLoad) && (command_i == lte_pkg::CmdWrite) && row_ok;
  assign waddr  = AW'(row_i);

  lte_ram #(.Width(32), .Depth(TableDepth)) u_ram_energy (
    .clk_i   (clk_i),
    .we_i    (wr_go && (column_i == lte_pkg::ColEnergy)),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (e_rd)
  );

  lte_ram #(.Width(32), .Depth(TableDepth)) u_ram_measured (
    .clk_i   (clk_i),
    .we_i    (wr_go && (column_i == lte_pkg::ColMeasured)),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (m_rd)
  );

  lte_ram #(.Width(32), .Depth(TableDepth)) u_ram_model (
    .clk_i   (clk_i),
    .we_i    (wr_go && (column_i == lte_pkg::ColModel)),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (d_rd)
  );

  // pass one: energy -> measured range; pass two: model range -> energy
  logic signed [31:0] x_rd, y_rd;
  assign x_rd = pass_q ? $signed(d_rd) : $signed(e_rd);
  assign y_rd = pass_q ? $signed(e_rd) : $signed(m_rd);

  // read address
  logic [CW-1:0] j_inc;
  assign j_inc = j_q + 1'b1;
  always_comb begin
    case (op_i)
      lte_pkg::OpRdLast:   raddr = AW'(nm1_w);
      lte_pkg::OpSrchNext: raddr = AW'(j_inc);
      lte_pkg::OpARd:      raddr = AW'(j_q + CW'(a_q));
      lte_pkg::OpBRd:      raddr = AW'(j_q + CW'(b_q));
      default:             raddr = '0;
    endcase
  end

  // window start, centered on the search hit and kept inside the table
  logic signed [CW:0] js_s;
  logic [CW-1:0]      win_w;
  always_comb begin
    js_s = $signed({1'b0, j_q}) - $signed({1'b0, order_w >> 1});
    if (js_s < 0) begin
      win_w = '0;
    end else begin
      win_w = CW'(js_s);
    end
    if ({1'b0, win_w} + {1'b0, order_w} > {1'b0, n_w}) begin
      win_w = n_w - order_w;
    end
  end

  // basis factor operands
  logic signed [32:0]          num_s, den_s;
  logic [32:0]                 num_mag, den_mag;
  logic [lte_pkg::NumW-1:0]    quo;
  logic                        div_busy;
  assign num_s   = {q_q[31], q_q} - {x_rd[31], x_rd};
  assign den_s   = {xa_q[31], xa_q} - {x_rd[31], x_rd};
  assign num_mag = num_s[32] ? 33'(-num_s) : 33'(num_s);
  assign den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);

  lte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op_i == lte_pkg::OpDivGo),
    .num_i   ({num_mag, {lte_pkg::FracBits{1'b0}}}),
    .den_i   (den_mag),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // factor saturated to +-2^31
  logic [31:0]        f_mag;
  logic signed [32:0] f_s;
  assign f_mag = (quo > lte_pkg::NumW'(33'h0_8000_0000)) ? 32'h8000_0000 : quo[31:0];
  assign f_s   = neg_q ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});

  // product scaled back, floor shift
  logic signed [65:0] sh_s;
  logic signed [32:0] lam_nx;
  assign sh_s = prod_q >>> lte_pkg::FracBits;
  always_comb begin
    if (sh_s > 66'sh0_0000_0000_8000_0000) begin
      lam_nx = 33'sh0_8000_0000;
    end else if (sh_s < -66'sh0_0000_0000_8000_0000) begin
      lam_nx = -33'sh0_8000_0000;
    end else begin
      lam_nx = sh_s[32:0];
    end
  end

  // next sum, and that sum saturated to 32 bits
  logic signed [47:0] acc_nx;
  logic signed [31:0] sat_w;
  assign acc_nx = dead_q ? sum_q : (sum_q + sh_s[47:0]);
  always_comb begin
    if (acc_nx > 48'sh0000_7FFF_FFFF) begin
      sat_w = 32'sh7FFF_FFFF;
    end else if (acc_nx < -48'sh0000_8000_0000) begin
      sat_w = -32'sh8000_0000;
    end else begin
      sat_w = acc_nx[31:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      lte_pkg::OpLoad: begin
        q_q         <= value_i;
        item_wr_q   <= (command_i == lte_pkg::CmdWrite);
        item_conv_q <= conv_q;
        pass_q      <= 1'b0;
        range_q     <= '0;
      end
      lte_pkg::OpTakeY:    res_q <= y_rd;
      lte_pkg::OpSrchGo:   j_q   <= '0;
      lte_pkg::OpSrchNext: j_q   <= j_inc;
      lte_pkg::OpWin: begin
        j_q   <= win_w;
        a_q   <= '0;
        sum_q <= '0;
      end
      lte_pkg::OpALd: begin
        xa_q   <= x_rd;
        ya_q   <= y_rd;
        lam_q  <= 33'sd16777216;
        dead_q <= 1'b0;
        b_q    <= '0;
      end
      lte_pkg::OpBInc: b_q    <= b_q + 1'b1;
      lte_pkg::OpDead: dead_q <= 1'b1;
      lte_pkg::OpDivGo: neg_q <= num_s[32] ^ den_s[32];
      lte_pkg::OpMulF: prod_q <= lam_q * f_s;
      lte_pkg::OpLam: begin
        lam_q <= lam_nx;
        b_q   <= b_q + 1'b1;
      end
      lte_pkg::OpMulY: prod_q <= ya_q * lam_q;
      lte_pkg::OpAcc: begin
        // last term of the window also saturates into the result
        sum_q <= acc_nx;
        if (status_o.a_last) res_q <= sat_w;
        a_q <= a_q + 1'b1;
      end
      lte_pkg::OpPass2: begin
        range_q <= res_q;
        q_q     <= res_q;
        pass_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_e_q, out_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == lte_pkg::OpOut) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == lte_pkg::OpOut) begin
      if (item_wr_q) begin
        out_e_q <= '0;
        out_r_q <= '0;
      end else if (!item_conv_q) begin
        out_e_q <= q_q;
        out_r_q <= '0;
      end else begin
        out_e_q <= res_q;
        out_r_q <= range_q;
      end
    end
  end

  // status to the controller
  always_comb begin
    status_o.in_write  = (command_i == lte_pkg::CmdWrite);
    status_o.conv_en   = conv_q;
    status_o.q_le_x    = (q_q <= x_rd);
    status_o.q_ge_x    = (q_q >= x_rd);
    status_o.srch_more = (x_rd < q_q) && (j_q < n_w);
    status_o.b_done    = (CW'(b_q) >= order_w);
    status_o.b_is_a    = (b_q == a_q);
    status_o.den_zero  = (den_s == '0);
    status_o.div_busy  = div_busy;
    status_o.a_last    = ((CW'(a_q) + 1'b1) == order_w);
    status_o.pass_two  = pass_q;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o          = out_valid_q;
  assign converted_energy_o   = out_e_q;
  assign interpolated_range_o = out_r_q;

endmodule

>>> design/lagrange_table_energy_correction.sv
// Energy correction by two Lagrange table passes over windows of up to
// PolyOrder points (4 by default). Write and pass-through items skip the
// passes and go to the output register; conversions search the table, then
// divide per basis factor, the bit-serial divider dominating. One item is in
// work at a time. Reset (async, active low) restores 32 points and conversion
// on; table contents are not cleared.
`timescale 1ns / 1ps
module lagrange_table_energy_correction #(
  parameter int unsigned TableDepth = lte_pkg::TableDepthDef,
  parameter int unsigned PolyOrder  = lte_pkg::PolyOrderDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [1:0]         column_i,
  input  logic [4:0]         row_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] converted_energy_o,
  output logic signed [31:0] interpolated_range_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i
);

  lte_pkg::op_e     op;
  lte_pkg::status_t status;

  // sequencer
  lte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  // tables and arithmetic
  lte_dp #(.TableDepth(TableDepth), .PolyOrder(PolyOrder)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .op_i                 (op),
    .status_o             (status),
    .command_i            (command_i),
    .column_i             (column_i),
    .row_i                (row_i),
    .value_i              (value_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .converted_energy_o   (converted_energy_o),
    .interpolated_range_o (interpolated_range_o)
  );

endmodule
